// File: hdl/c2s_pkg.sv
`default_nettype none

package c2s_pkg;

   // default fraction width of the internal fixed point
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int FACE_W   = 3;
   localparam int COORD_W  = 17;
   localparam int RADIUS_W = 24;
   localparam int POS_W    = 25;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // 1.0 in the Q1.16 face coordinates
   localparam logic [COORD_W-1:0] COORD_ONE = 17'd65536;

   // register word indexes (byte address / 4)
   localparam logic REG_SPHERE_RADIUS = 1'b0;

   // face codes
   localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd0;
   localparam logic [FACE_W-1:0] FACE_BACK   = 3'd1;
   localparam logic [FACE_W-1:0] FACE_TOP    = 3'd2;
   localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd3;
   localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd4;
   localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd5;

endpackage

`default_nettype wire

// File: hdl/cube_to_sphere_point.sv
`default_nettype none

// Spherified-cube point mapper. A request word carries a cube face code and face
// coordinates u,v in Q1.16 (0..1, larger values saturate to 1.0); the response word
// is the matching point on a sphere of radius sphere_radius meters, each axis
// rounded to whole meters, with bad_face set and zero position for face codes 6
// and 7. The block is a fully pipelined datapath: one word enters per clock and
// one leaves per clock while the output is not stalled; most of the pipeline is
// the square-root pipeline, which resolves one root bit per stage. A stalled
// response freezes the whole pipeline, so req_ready follows rsp_ready while the
// output register is full. sphere_radius lives at byte address 0 of the APB
// port and should only be written while no words are in flight.
module cube_to_sphere_point
   import c2s_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // request words
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [FACE_W-1:0]          req_face_sel,
   input  logic [COORD_W-1:0]         req_coord_u,
   input  logic [COORD_W-1:0]         req_coord_v,
   // response words
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [POS_W-1:0]    rsp_pos_x,
   output logic signed [POS_W-1:0]    rsp_pos_y,
   output logic signed [POS_W-1:0]    rsp_pos_z,
   output logic                       rsp_bad_face,
   // configuration
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_DW-1:0]          csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

   localparam int F     = FRAC_BITS;
   localparam int W     = F + 2;       // signed component, |c| <= 1.0
   localparam int SQ_W  = 2 * F + 1;   // square of a component
   localparam int A_W   = F + 1;       // rounded square, 0..1.0
   localparam int AB_W  = 2 * F + 2;   // product of two squares
   localparam int T_W   = F + 3;       // spherify numerator over ONE
   localparam int TX_W  = F + 4;
   localparam int N_W   = F + 2;       // numerator halved, ahead of the divide by 3
   localparam int K3    = F + 3;       // reciprocal shift for the divide by 3
   localparam int DP_W  = 2 * F + 4;
   localparam int S_W   = F + 1;       // spherify factor
   localparam int CR_W  = 2 * F + 4;
   localparam int M_W   = F + 27;
   localparam int L16_W = 19;
   localparam int CSTG  = 7;           // stages ahead of the square root
   localparam int LAT   = F + 13;

   localparam logic [DP_W-1:0] RECIP3 = DP_W'(((64'd1 << K3) + 64'd2) / 64'd3);
   localparam logic [TX_W-1:0] T_BASE = TX_W'((64'd6 << F) + 64'd3);
   localparam logic signed [W-1:0] ONE_S = W'(64'd1 << F);
   localparam logic [SQ_W-1:0] HALF_SQ = SQ_W'(64'd1 << (F - 1));
   localparam logic signed [CR_W-1:0] HALF_CR = CR_W'(64'd1 << (F - 1));
   localparam logic signed [M_W-1:0] HALF_M = M_W'(64'd1 << (F - 1));

   // ---------------------------------------------------------------- control
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] bad_ff;
   logic           en;

   // the whole pipeline moves unless a finished word sits unaccepted at the output
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_bad_face = bad_ff[LAT-1];

   // --------------------------------------------------------- configuration
   logic [RADIUS_W-1:0] radius_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SPHERE_RADIUS) ?
                       CSR_DW'(radius_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_SPHERE_RADIUS) begin
         radius_ff <= csr_pwdata[RADIUS_W-1:0];
      end
   end

   // --------------------------------------------- stage 1: local coordinates
   logic [COORD_W-1:0]     u_sat, v_sat;
   logic signed [L16_W-1:0] l16_u, l16_v;
   logic signed [W-1:0]    lx, ly;

   always_comb begin
      u_sat = (req_coord_u > COORD_ONE) ? COORD_ONE : req_coord_u;
      v_sat = (req_coord_v > COORD_ONE) ? COORD_ONE : req_coord_v;
      // 2u - 1.0 in Q.16
      l16_u = $signed({1'b0, u_sat, 1'b0}) - $signed(L16_W'(COORD_ONE));
      l16_v = $signed({1'b0, v_sat, 1'b0}) - $signed(L16_W'(COORD_ONE));
   end

   // rescale Q.16 to Q.F: exact shift up, or round to nearest going down
   if (F >= 16) begin : g_scale_up
      assign lx = W'(l16_u) <<< (F - 16);
      assign ly = W'(l16_v) <<< (F - 16);
   end else begin : g_scale_down
      localparam int SH = 16 - F;
      localparam logic signed [L16_W-1:0] LHALF = L16_W'(64'd1 << (SH - 1));
      logic signed [L16_W-1:0] sum_u, sum_v;
      assign sum_u = l16_u + LHALF;
      assign sum_v = l16_v + LHALF;
      assign lx = W'(sum_u >>> SH);
      assign ly = W'(sum_v >>> SH);
   end

   logic signed [W-1:0] p1_c_in [3];
   logic                p1_bad_in;

   // place the local point on the selected face
   always_comb begin
      p1_bad_in = 1'b0;
      p1_c_in[0] = '0;
      p1_c_in[1] = '0;
      p1_c_in[2] = '0;
      case (req_face_sel)
         FACE_FRONT: begin
            p1_c_in[0] = ONE_S;  p1_c_in[1] = ly;     p1_c_in[2] = -lx;
         end
         FACE_BACK: begin
            p1_c_in[0] = -ONE_S; p1_c_in[1] = ly;     p1_c_in[2] = lx;
         end
         FACE_TOP: begin
            p1_c_in[0] = lx;     p1_c_in[1] = ONE_S;  p1_c_in[2] = -ly;
         end
         FACE_BOTTOM: begin
            p1_c_in[0] = lx;     p1_c_in[1] = -ONE_S; p1_c_in[2] = ly;
         end
         FACE_RIGHT: begin
            p1_c_in[0] = lx;     p1_c_in[1] = ly;     p1_c_in[2] = ONE_S;
         end
         FACE_LEFT: begin
            p1_c_in[0] = -lx;    p1_c_in[1] = ly;     p1_c_in[2] = -ONE_S;
         end
         default: begin
            p1_bad_in = 1'b1;
         end
      endcase
   end

   // ----------------------------------------------------- payload registers
   logic signed [W-1:0]    c_ff    [CSTG][3];  // component, stages 1..7
   logic [SQ_W-1:0]        sq_ff   [3];        // stage 2
   logic [A_W-1:0]         a_ff    [3];        // stage 3
   logic [AB_W-1:0]        ab_ff   [3];        // stage 4
   logic [A_W:0]           sumab_ff[3];        // stage 4
   logic [T_W-1:0]         t_ff    [3];        // stage 5
   logic [DP_W-1:0]        dp_ff   [3];        // stage 6
   logic [S_W-1:0]         s_ff    [3];        // stage 7
   logic signed [CR_W-1:0] cr_ff   [3];        // after the root
   logic signed [W-1:0]    q_ff    [3];
   logic signed [M_W-1:0]  mr_ff   [3];
   logic signed [POS_W-1:0] pos_ff [3];

   logic signed [2*W-1:0]  sq_full [3];
   logic [SQ_W-1:0]        sq_rnd  [3];
   logic [SQ_W-1:0]        sq_in   [3];
   logic [A_W-1:0]         a_in    [3];
   logic [AB_W-1:0]        ab_in   [3];
   logic [A_W:0]           sumab_in[3];
   logic [TX_W-1:0]        t_wide  [3];
   logic [T_W-1:0]         t_in    [3];
   logic [DP_W-1:0]        dp_in   [3];
   logic [S_W-1:0]         s_in    [3];
   logic [S_W-1:0]         root_w  [3];
   logic signed [W-1:0]    ctag_w  [3];
   logic signed [CR_W-1:0] cr_in   [3];
   logic signed [CR_W-1:0] cr_rnd  [3];
   logic signed [W-1:0]    q_in    [3];
   logic signed [M_W-1:0]  mr_in   [3];
   logic signed [M_W-1:0]  mr_rnd  [3];
   logic signed [POS_W-1:0] pos_in [3];

   // lane k spherifies component k against the other two, k+1 and k+2 mod 3
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         // stage 2: square
         sq_full[k] = c_ff[0][k] * c_ff[0][k];
         sq_in[k]   = sq_full[k][SQ_W-1:0];
         // stage 3: round the square back to Q.F
         sq_rnd[k]  = sq_ff[k] + HALF_SQ;
         a_in[k]    = sq_rnd[k][SQ_W-1:F];
         // stage 4: a*b and a+b of the two other lanes
         ab_in[k]    = AB_W'(a_ff[(k + 1) % 3]) * AB_W'(a_ff[(k + 2) % 3]);
         sumab_in[k] = (A_W + 1)'(a_ff[(k + 1) % 3]) + (A_W + 1)'(a_ff[(k + 2) % 3]);
         // stage 5: 6*ONE + 3 - 3(a+b) + floor(2ab/ONE)
         t_wide[k] = T_BASE + TX_W'(ab_ff[k][2*F:F-1])
                     - (TX_W'({sumab_ff[k], 1'b0}) + TX_W'(sumab_ff[k]));
         t_in[k]   = t_wide[k][T_W-1:0];
         // stage 6: floor(t/2) times the reciprocal of 3
         dp_in[k]  = DP_W'(t_ff[k][T_W-1:1]) * RECIP3;
         // stage 7: spherify factor s = floor(t/6)
         s_in[k]   = dp_ff[k][K3+F:K3];
         // after the root: c * r, rounded back to Q.F
         cr_in[k]  = CR_W'(ctag_w[k]) * CR_W'($signed({1'b0, root_w[k]}));
         cr_rnd[k] = cr_ff[k] + HALF_CR;
         q_in[k]   = W'(cr_rnd[k] >>> F);
         // scale by the radius and round to meters
         mr_in[k]  = M_W'(q_ff[k]) * M_W'($signed({1'b0, radius_ff}));
         mr_rnd[k] = mr_ff[k] + HALF_M;
         pos_in[k] = bad_ff[LAT-2] ? '0 : POS_W'(mr_rnd[k] >>> F);
      end
   end

   // three lanes of the square-root pipeline, component riding along as tag
   for (genvar k = 0; k < 3; k++) begin : g_lane
      c2s_sqrt #(
         .IN_W  (S_W),
         .TAG_W (W)
      ) u_sqrt (
         .clock    (clock),
         .en       (en),
         .rad_in   (s_ff[k]),
         .tag_in   (c_ff[CSTG-1][k]),
         .root_out (root_w[k]),
         .tag_out  (ctag_w[k])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            c_ff[0][k] <= p1_c_in[k];
            for (int j = 1; j < CSTG; j++) begin
               c_ff[j][k] <= c_ff[j-1][k];
            end
            sq_ff[k]    <= sq_in[k];
            a_ff[k]     <= a_in[k];
            ab_ff[k]    <= ab_in[k];
            sumab_ff[k] <= sumab_in[k];
            t_ff[k]     <= t_in[k];
            dp_ff[k]    <= dp_in[k];
            s_ff[k]     <= s_in[k];
            cr_ff[k]    <= cr_in[k];
            q_ff[k]     <= q_in[k];
            mr_ff[k]    <= mr_in[k];
            pos_ff[k]   <= pos_in[k];
         end
      end
   end

   // valid and bad-face flags travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         bad_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
         bad_ff <= {bad_ff[LAT-2:0], p1_bad_in};
      end
   end

   assign rsp_pos_x = pos_ff[0];
   assign rsp_pos_y = pos_ff[1];
   assign rsp_pos_z = pos_ff[2];

endmodule

`default_nettype wire

// File: hdl/c2s_sqrt.sv
`default_nettype none

// pipelined square root of (rad_in << (IN_W-1)), rounded to nearest
module c2s_sqrt #(
   parameter int IN_W  = 17,
   parameter int TAG_W = 18
) (
   input  logic             clock,
   input  logic             en,
   input  logic [IN_W-1:0]  rad_in,
   input  logic [TAG_W-1:0] tag_in,
   output logic [IN_W-1:0]  root_out,
   output logic [TAG_W-1:0] tag_out
);

   localparam int H     = IN_W;
   localparam int RW    = H + 2;
   localparam int CW    = H + 4;
   localparam int RAD_W = 2 * H;

   logic [RW-1:0]    rem_ff  [H];
   logic [H-1:0]     root_ff [H];
   logic [IN_W-1:0]  rad_ff  [H];
   logic [TAG_W-1:0] tag_ff  [H];
   logic [H-1:0]     res_ff;
   logic [TAG_W-1:0] tag_out_ff;

   // one root bit per stage
   for (genvar i = 0; i < H; i++) begin : g_step
      logic [RW-1:0]    rem_prev;
      logic [H-1:0]     root_prev;
      logic [IN_W-1:0]  rad_prev;
      logic [TAG_W-1:0] tag_prev;
      logic [RAD_W-1:0] rad_full;
      logic [CW-1:0]    cand;
      logic [CW-1:0]    trial;
      logic [RW-1:0]    rem_in;
      logic [H-1:0]     root_in;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = rad_in;
         assign tag_prev  = tag_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
         assign tag_prev  = tag_ff[i-1];
      end

      always_comb begin
         rad_full = {1'b0, rad_prev, {(H-1){1'b0}}};
         cand     = {rem_prev, rad_full[RAD_W-1-2*i -: 2]};
         trial    = CW'({root_prev, 2'b01});
         if (cand >= trial) begin
            rem_in  = RW'(cand - trial);
            root_in = {root_prev[H-2:0], 1'b1};
         end else begin
            rem_in  = RW'(cand);
            root_in = {root_prev[H-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            rad_ff[i]  <= rad_prev;
            tag_ff[i]  <= tag_prev;
         end
      end
   end

   // round up when the remainder exceeds the floor root
   always_ff @(posedge clock) begin
      if (en) begin
         res_ff     <= (rem_ff[H-1] > RW'(root_ff[H-1])) ? root_ff[H-1] + H'(1)
                                                         : root_ff[H-1];
         tag_out_ff <= tag_ff[H-1];
      end
   end

   assign root_out = res_ff;
   assign tag_out  = tag_out_ff;

endmodule

`default_nettype wire

// File: hdl/c2s_checker.sv
`default_nettype none

module c2s_checker
   import c2s_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [POS_W-1:0] rsp_pos_x,
   input logic signed [POS_W-1:0] rsp_pos_y,
   input logic signed [POS_W-1:0] rsp_pos_z,
   input logic                    rsp_bad_face
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) &&
      $stable(rsp_pos_y) && $stable(rsp_pos_z) && $stable(rsp_bad_face))
      else $error("response word changed while stalled");

   // bad face gives a zero position
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_face |-> rsp_pos_x == '0 && rsp_pos_y == '0 &&
      rsp_pos_z == '0)
      else $error("bad face with nonzero position");

   // input side only blocks while a finished word waits
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready out of step with output stall");

   // no response right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind cube_to_sphere_point c2s_checker u_c2s_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_pos_x    (rsp_pos_x),
   .rsp_pos_y    (rsp_pos_y),
   .rsp_pos_z    (rsp_pos_z),
   .rsp_bad_face (rsp_bad_face)
);

`default_nettype wire

// File: tb/cube_to_sphere_point_tb.sv
`default_nettype none

module cube_to_sphere_point_tb;
   import c2s_pkg::*;

   localparam int FB = FRAC_BITS_DEFAULT;
   localparam int LATENCY = FB + 13;

   // expected response word
   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] z;
      logic                    bad;
   } point_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [FACE_W-1:0]       req_face_sel = '0;
   logic [COORD_W-1:0]      req_coord_u = '0;
   logic [COORD_W-1:0]      req_coord_v = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic signed [POS_W-1:0] rsp_pos_z;
   logic                    rsp_bad_face;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]       csr_paddr = '0;
   logic [CSR_DW-1:0]       csr_pwdata = '0;
   logic [CSR_DW-1:0]       csr_prdata;
   logic                    csr_pready;

   // predictor copy of the radius register
   logic [RADIUS_W-1:0] radius_m = '0;
   point_type           points_due[$];
   int                  error_count = 0;

   cube_to_sphere_point dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------- predictor ----------------

   // shift right rounding to nearest, ties toward +inf (arithmetic shift floors)
   function automatic longint rnd_shr(longint x, int s);
      if (s == 0) return x;
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint root_nearest(longint n);
      longint lo;
      longint hi;
      longint mid;
      longint rem;
      lo = 0;
      hi = 64'd3037000499;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= n) lo = mid;
         else hi = mid - 1;
      end
      rem = n - lo * lo;
      if (rem > lo) lo = lo + 1;
      return lo;
   endfunction

   function automatic longint face_local(logic [COORD_W-1:0] c);
      longint c16;
      c16 = (c > COORD_ONE) ? longint'(COORD_ONE) : longint'(c);
      c16 = 2 * c16 - 65536;
      if (FB >= 16) return c16 <<< (FB - 16);
      return rnd_shr(c16, 16 - FB);
   endfunction

   // one component of the spherified cube, scaled to meters
   function automatic logic signed [POS_W-1:0] sphere_axis(longint c, longint o1,
                                                             longint o2);
      longint one;
      longint a;
      longint b;
      longint num;
      longint s;
      longint q;
      one = longint'(1) << FB;
      a = rnd_shr(o1 * o1, FB);
      b = rnd_shr(o2 * o2, FB);
      num = 6 * one * one - 3 * one * a - 3 * one * b + 2 * a * b;
      s = (num + 3 * one) / (6 * one);
      if (s < 0) s = 0;
      q = rnd_shr(c * root_nearest(s << FB), FB);
      return POS_W'(rnd_shr(q * longint'(radius_m), FB));
   endfunction

   function automatic point_type map_point(logic [FACE_W-1:0] face,
                                           logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
      longint one;
      longint lx;
      longint ly;
      longint px;
      longint py;
      longint pz;
      point_type p;
      one = longint'(1) << FB;
      lx = face_local(u);
      ly = face_local(v);
      p = '0;
      case (face)
         FACE_FRONT: begin px = one;  py = ly;   pz = -lx; end
         FACE_BACK: begin px = -one; py = ly;   pz = lx; end
         FACE_TOP: begin px = lx;   py = one;  pz = -ly; end
         FACE_BOTTOM: begin px = lx;   py = -one; pz = ly; end
         FACE_RIGHT: begin px = lx;   py = ly;   pz = one; end
         FACE_LEFT: begin px = -lx;  py = ly;   pz = -one; end
         default: begin
            p.bad = 1'b1;
            return p;
         end
      endcase
      p.x = sphere_axis(px, py, pz);
      p.y = sphere_axis(py, pz, px);
      p.z = sphere_axis(pz, px, py);
      return p;
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // response stall pattern: a random wait drawn per word
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (reset) continue;
         if (rsp_ready && rsp_valid) begin
            gap = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
               rsp_ready <= 1'b1;
            end
         end else if (!rsp_ready) begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare every accepted response word with the oldest prediction
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (points_due.size() == 0) begin
            report_mismatch("unexpected word", 0, 0);
         end else begin
            want = points_due.pop_front();
            if (rsp_pos_x !== want.x) report_mismatch("pos_x", rsp_pos_x, want.x);
            if (rsp_pos_y !== want.y) report_mismatch("pos_y", rsp_pos_y, want.y);
            if (rsp_pos_z !== want.z) report_mismatch("pos_z", rsp_pos_z, want.z);
            if (rsp_bad_face !== want.bad)
               report_mismatch("bad_face", rsp_bad_face, want.bad);
         end
      end
   end

   // ---------------- stimulus ----------------

   // send one request word after a random idle gap; valid stays up after the
   // accept until the next call or drain decides what comes next
   task automatic send_point(logic [FACE_W-1:0] face, logic [COORD_W-1:0] u,
                             logic [COORD_W-1:0] v);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_face_sel <= face;
      req_coord_u  <= u;
      req_coord_v  <= v;
      // prediction uses the radius in force now; writes happen only when idle
      points_due.insert(points_due.size(), map_point(face, u, v));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (points_due.size() != 0) @(posedge clock);
      // pipeline has no word without a response, but let it settle anyway
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_radius(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      // the only register sits at word 0; the predictor follows only writes to byte address 0
      if (addr[CSR_AW-1:2] == {(CSR_AW-2){1'b0}} && addr[1:0] == 2'b00)
         radius_m = value[RADIUS_W-1:0];
      @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] any_coord();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return COORD_ONE;
         2: return COORD_W'($urandom);  // may exceed one, saturates
         default: return COORD_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // corners, edges, center and saturating coordinates on every face
   task automatic test_directed();
      logic [FACE_W-1:0] f;
      for (int i = 0; i < 8; i++) begin
         f = FACE_W'(i);
         send_point(f, '0, '0);
         send_point(f, COORD_ONE, 17'd32768);
      end
      send_point(FACE_FRONT, '1, '1);
      send_point(FACE_RIGHT, 17'h10001, '0);
      send_point(FACE_TOP, 17'd1, 17'd65535);
      send_point(FACE_LEFT, 17'h15555, 17'h0AAAA);
      send_point(FACE_BOTTOM, 17'd32768, 17'd32768);
      send_point(3'd7, '1, '1);
   endtask

   task automatic test_random(int count);
      logic [FACE_W-1:0] f;
      for (int i = 0; i < count; i++) begin
         f = ($urandom_range(0, 9) == 0) ? FACE_W'($urandom_range(6, 7))
                                         : FACE_W'($urandom_range(0, 5));
         send_point(f, any_coord(), any_coord());
      end
   endtask

   // radius sweep including extremes; also an unmapped address that must not stick
   task automatic test_radius_sweep();
      logic [CSR_DW-1:0] radii[4];
      radii[0] = 32'h00FF_FFFF;
      radii[1] = 32'd1;
      radii[2] = 32'd6371000;
      radii[3] = 32'hFF00_0000 | 32'($urandom_range(0, 24'hFFFFFF));
      foreach (radii[k]) begin
         drain();
         write_radius(3'd0, radii[k]);
         if (k == 1) write_radius(3'd4, 32'h00AB_CDEF);
         test_random(90);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // radius zero after reset
      test_directed();
      drain();
      write_radius(3'd0, 32'h00FF_FFFF);
      test_directed();
      test_radius_sweep();
      drain();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(12 * 200000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
